/* rtl/kvl_pkg.sv */
`default_nettype none
package kvl_pkg;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LAST,
        ST_RD_FIRST,
        ST_DECIDE,
        ST_SEARCH,
        ST_RD_PAIR,
        ST_DIVIDE,
        ST_MUL,
        ST_SUM,
        ST_ENDT,
        ST_OUT
    } state_t;

    localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

    // read address select codes
    localparam logic [1:0] ADDR_LAST  = 2'd0;
    localparam logic [1:0] ADDR_FIRST = 2'd1;
    localparam logic [1:0] ADDR_NEXT  = 2'd2;
    localparam logic [1:0] ADDR_CUR   = 2'd3;

    // datapath commands
    typedef struct packed {
        logic       load_item;
        logic       set_addr;     // read address select strobe
        logic [1:0] addr_sel;     // last, first, index i+1, index i
        logic       cap_last;
        logic       cap_cur;
        logic       cap_nxt;
        logic       res_default;
        logic       res_last;
        logic       res_first;
        logic       res_nxt;
        logic       div_start;
        logic       div_step;
        logic       mul_step;
        logic       sum_step;
        logic       endt_step;
        logic       out_load;
        logic       idx_clear;
        logic       idx_inc;
    } dp_cmd_t;

    // datapath status
    typedef struct packed {
        logic       func_clear;
        logic       func_append;
        logic       func_query;
        logic       cnt_zero;
        logic       cnt_one;
        logic       after_last;
        logic       before_first;
        logic       search_done;
        logic       seg_empty;
        logic       frac_full;
        logic       div_done;
        logic       endt_done;
    } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/kvl_if.sv */
`default_nettype none
interface kvl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        track;
    logic [31:0] key_time;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    modport source (output valid, func, track, key_time, in_x, in_y, in_z, input ready);
    modport sink (input valid, func, track, key_time, in_x, in_y, in_z, output ready);
endinterface

interface kvl_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0] end_time;
    logic        in_use;
    logic        store_full;
    modport source (output valid, out_x, out_y, out_z, end_time, in_use, store_full,
                    input ready);
    modport sink (input valid, out_x, out_y, out_z, end_time, in_use, store_full,
                  output ready);
endinterface
`default_nettype wire

/* rtl/kvl_ram.sv */
`default_nettype none
module kvl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/kvl_ctrl.sv */
`default_nettype none
module kvl_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire kvl_pkg::dp_sts_t sts,
    output kvl_pkg::dp_cmd_t     cmd
);
    import kvl_pkg::*;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_RD_LAST;
                end
            end
            ST_RD_LAST:
            begin
                // item registered; append, clear and func 3 finish here
                if (!sts.func_query)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.set_addr = 1'b1;
                    cmd.addr_sel = ADDR_LAST;
                    state_next   = ST_RD_FIRST;
                end
            end
            ST_RD_FIRST:
            begin
                cmd.cap_last = 1'b1;
                cmd.set_addr = 1'b1;
                cmd.addr_sel = ADDR_FIRST;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.idx_clear = 1'b1;
                cmd.set_addr  = 1'b1;
                cmd.addr_sel  = ADDR_NEXT;
                if (sts.cnt_zero)
                begin
                    cmd.res_default = 1'b1;
                    state_next      = ST_ENDT;
                end
                else if (sts.cnt_one || sts.after_last)
                begin
                    cmd.res_last = 1'b1;
                    state_next   = ST_ENDT;
                end
                else if (sts.before_first)
                begin
                    cmd.res_first = 1'b1;
                    state_next    = ST_ENDT;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // time[i+1] read data is valid in this state and is captured
                cmd.cap_nxt = 1'b1;
                state_next  = ST_RD_PAIR;
            end
            ST_RD_PAIR:
            begin
                if (sts.search_done)
                begin
                    cmd.set_addr = 1'b1;
                    cmd.addr_sel = ADDR_CUR;
                    state_next   = ST_DIVIDE;
                    cnt_next     = '0;
                end
                else
                begin
                    cmd.idx_inc  = 1'b1;
                    cmd.set_addr = 1'b1;
                    cmd.addr_sel = ADDR_NEXT;
                    state_next   = ST_SEARCH;
                end
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == 5'd0)
                begin
                    cmd.cap_cur   = 1'b1;
                    cmd.div_start = 1'b1;
                    cnt_next      = 5'd1;
                end
                else if (sts.seg_empty)
                begin
                    cmd.res_nxt = 1'b1;
                    state_next  = ST_ENDT;
                end
                else if (!sts.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else if (sts.frac_full)
                begin
                    cmd.res_nxt = 1'b1;
                    state_next  = ST_ENDT;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'd5)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                state_next   = ST_ENDT;
            end
            ST_ENDT:
            begin
                cmd.endt_step = 1'b1;
                if (sts.endt_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/kvl_dp.sv */
`default_nettype none
module kvl_dp #(
    parameter int MAX_KEYS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [1:0]         func,
    input  wire logic               track,
    input  wire logic [31:0]        key_time,
    input  wire logic signed [31:0] in_x,
    input  wire logic signed [31:0] in_y,
    input  wire logic signed [31:0] in_z,
    input  wire kvl_pkg::dp_cmd_t   cmd,
    output kvl_pkg::dp_sts_t        sts,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic [31:0]             end_time,
    output logic                    in_use,
    output logic                    store_full
);
    import kvl_pkg::*;

    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int AW = IW + 1;

    // item registers
    func_t       func_reg;
    logic        trk_reg;
    logic [31:0] t_reg;
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] n;

    // memory
    logic          we;
    logic [AW-1:0] waddr, raddr_reg, raddr_next;
    logic [31:0]   time_rd;
    logic [95:0]   vec_rd;

    // search
    logic [IW-1:0] idx_reg;
    logic [31:0]   last_t_reg, nxt_t_reg, cur_t_reg;
    logic [95:0]   last_v_reg, nxt_v_reg;

    // divider
    logic [31:0] den_reg;
    logic [32:0] rem_reg;
    logic [31:0] dnum_reg;
    logic [16:0] q_reg;
    logic [32:0] rem_sh;
    logic [33:0] rem_sub;

    // multiplier
    logic [2:0]          mcnt_reg;
    logic signed [49:0]  prod_reg;
    logic signed [49:0]  acc_reg [3];
    logic signed [49:0]  acc2_sum;
    logic signed [31:0]  mul_a;
    logic signed [17:0]  mul_b;
    logic [1:0]          comp;

    // result
    logic [95:0] res_reg;
    logic [31:0] endt_reg;
    logic [1:0]  estep_reg;
    logic [31:0] lt0_reg;

    assign n = cnt_reg[trk_reg];

    // item and key counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            func_reg   <= FUNC_NONE;
        end
        else if (cmd.load_item)
        begin
            func_reg <= func_t'(func);
            if (func_t'(func) == FUNC_CLEAR)
            begin
                cnt_reg[track] <= '0;
            end
            else if (func_t'(func) == FUNC_APPEND && cnt_reg[track] < CW'(MAX_KEYS))
            begin
                cnt_reg[track] <= cnt_reg[track] + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            trk_reg <= track;
            t_reg   <= key_time;
        end
    end

    assign we    = cmd.load_item && func_t'(func) == FUNC_APPEND
                   && cnt_reg[track] < CW'(MAX_KEYS);
    assign waddr = {track, cnt_reg[track][IW-1:0]};

    // read address goes straight to the memory; data is registered and arrives in the next cycle
    kvl_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_time_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(key_time),
        .raddr(raddr_next), .rdata(time_rd)
    );

    kvl_ram #(.WIDTH(96), .DEPTH(2 ** AW)) u_vec_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata({in_x, in_y, in_z}),
        .raddr(raddr_next), .rdata(vec_rd)
    );

    // read address select
    always_comb
    begin
        raddr_next = raddr_reg;
        if (cmd.endt_step)
        begin
            raddr_next = (estep_reg == 2'd0)
                ? {1'b0, IW'(cnt_reg[0] - CW'(1))}
                : {1'b1, IW'(cnt_reg[1] - CW'(1))};
        end
        else if (cmd.set_addr)
        begin
            unique case (cmd.addr_sel)
                ADDR_LAST:  raddr_next = {trk_reg, IW'(n - CW'(1))};
                ADDR_FIRST: raddr_next = {trk_reg, {IW{1'b0}}};
                ADDR_NEXT:  raddr_next = {trk_reg, (cmd.idx_clear ? IW'(1)
                                   : (cmd.idx_inc ? idx_reg + IW'(2) : idx_reg + IW'(1)))};
                default:    raddr_next = {trk_reg, idx_reg};
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_reg <= raddr_next;
        if (cmd.cap_last)
        begin
            last_t_reg <= time_rd;
            last_v_reg <= vec_rd;
        end
        if (cmd.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.cap_nxt)
        begin
            nxt_t_reg <= time_rd;
            nxt_v_reg <= vec_rd;
        end
        if (cmd.cap_cur)
        begin
            // vector i arrives with time i
            cur_t_reg  <= time_rd;
            last_v_reg <= vec_rd;
        end
    end

    // search stops at the last segment or at the first end time not below t
    assign sts.search_done = (CW'(idx_reg) + CW'(2) >= n) || !(nxt_t_reg < t_reg);

    // restoring divider, one quotient bit a cycle
    assign rem_sh  = {rem_reg[31:0], dnum_reg[31]};
    assign rem_sub = {1'b0, rem_sh} - {2'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            den_reg  <= nxt_t_reg - time_rd;
            rem_reg  <= '0;
            // numerator (t - cur) << 16, fed MSB first over 48 bits
            dnum_reg <= t_reg - time_rd;
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[33])
            begin
                rem_reg <= rem_sub[32:0];
                q_reg   <= {q_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[15:0], 1'b0};
            end
            dnum_reg <= {dnum_reg[30:0], 1'b0};
        end
    end

    // quotient bits above 16 are always zero since t-cur <= nxt-cur;
    // so simply run 48 steps with a 17-bit window (high bits vanish).
    logic [5:0] dsteps_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dsteps_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dsteps_reg <= dsteps_reg + 6'd1;
        end
    end
    assign sts.div_done  = (dsteps_reg == 6'd48);
    assign sts.frac_full = q_reg[16];
    assign sts.seg_empty = !(cur_t_reg < nxt_t_reg);

    // blend as v0 + (v1 - v0)*a would differ in rounding; use two products
    always_comb
    begin
        comp  = 2'(mcnt_reg >> 1);
        mul_b = mcnt_reg[0] ? $signed({1'b0, q_reg})
                            : $signed(18'sd65536 - $signed({1'b0, q_reg}));
        unique case (comp)
            2'd0:    mul_a = mcnt_reg[0] ? $signed(nxt_v_reg[95:64]) : $signed(last_v_reg[95:64]);
            2'd1:    mul_a = mcnt_reg[0] ? $signed(nxt_v_reg[63:32]) : $signed(last_v_reg[63:32]);
            default: mul_a = mcnt_reg[0] ? $signed(nxt_v_reg[31:0])  : $signed(last_v_reg[31:0]);
        endcase
    end

    assign acc2_sum = acc_reg[2] + prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            mcnt_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            mcnt_reg <= mcnt_reg + 3'd1;
            prod_reg <= 50'(mul_a * mul_b);
            if (mcnt_reg != 3'd0)
            begin
                if (mcnt_reg[0])
                begin
                    acc_reg[2'(((mcnt_reg - 3'd1) >> 1))] <= prod_reg;
                end
                else
                begin
                    acc_reg[2'(((mcnt_reg - 3'd2) >> 1))] <=
                        acc_reg[2'(((mcnt_reg - 3'd2) >> 1))] + prod_reg;
                end
            end
        end
        else if (cmd.sum_step)
        begin
            acc_reg[2] <= acc2_sum;
        end
    end

    // result selection
    always_ff @(posedge clk)
    begin
        if (cmd.res_default)
        begin
            res_reg <= trk_reg ? {SCALE_ONE, SCALE_ONE, SCALE_ONE} : '0;
        end
        else if (cmd.res_last)
        begin
            res_reg <= last_v_reg;
        end
        else if (cmd.res_first)
        begin
            res_reg <= vec_rd;
        end
        else if (cmd.res_nxt)
        begin
            res_reg <= nxt_v_reg;
        end
        else if (cmd.sum_step)
        begin
            res_reg <= {acc_reg[0][47:16], acc_reg[1][47:16], acc2_sum[47:16]};
        end
    end

    // end time: read each track's last key
    always_ff @(posedge clk)
    begin
        if (!cmd.endt_step)
        begin
            estep_reg <= '0;
        end
        else
        begin
            estep_reg <= estep_reg + 2'd1;
            if (estep_reg == 2'd1)
            begin
                lt0_reg <= (cnt_reg[0] >= CW'(2)) ? time_rd : '0;
            end
            if (estep_reg == 2'd2)
            begin
                endt_reg <= (cnt_reg[1] >= CW'(2) && time_rd > lt0_reg) ? time_rd : lt0_reg;
            end
        end
    end
    assign sts.endt_done = cmd.endt_step && estep_reg == 2'd2;

    // ENDT address: step 0 issues track 0 read, step 1 issues track 1
    // (handled by raddr_next with estep_reg; step 1 updates to track 1)

    // status
    assign sts.func_clear   = func_reg == FUNC_CLEAR;
    assign sts.func_append  = func_reg == FUNC_APPEND;
    assign sts.func_query   = func_reg == FUNC_QUERY;
    assign sts.cnt_zero     = n == '0;
    assign sts.cnt_one      = n == CW'(1);
    assign sts.after_last   = t_reg > last_t_reg;
    assign sts.before_first = !(t_reg > time_rd);

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_x      <= res_reg[95:64];
            out_y      <= res_reg[63:32];
            out_z      <= res_reg[31:0];
            end_time   <= endt_reg;
            in_use     <= (cnt_reg[0] != '0) || (cnt_reg[1] != '0);
            store_full <= n >= CW'(MAX_KEYS);
        end
    end
endmodule
`default_nettype wire

/* rtl/keyframe_vector_lerp.sv */
`default_nettype none
// Channel | Dir | Payload
// in      | in  | func, track, key_time, in_x, in_y, in_z
// out     | out | out_x, out_y, out_z, end_time, in_use, store_full
//
// Clear and append end once the item is registered; a query reads the
// last and first keys, searches key by key and, to interpolate, divides
// and blends, at a pace set by the single key memory read port and the
// bit-serial divider. Reset empties both tracks. A result waits in the
// output register; the sequencer holds while it is not taken.
module keyframe_vector_lerp #(
    parameter int MAX_KEYS = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    kvl_in_if.sink   in_ch,
    kvl_out_if.source out_ch
);
    import kvl_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    kvl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .sts(sts), .cmd(cmd)
    );

    kvl_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .func(in_ch.func), .track(in_ch.track), .key_time(in_ch.key_time),
        .in_x(in_ch.in_x), .in_y(in_ch.in_y), .in_z(in_ch.in_z),
        .cmd(cmd), .sts(sts),
        .out_x(out_ch.out_x), .out_y(out_ch.out_y), .out_z(out_ch.out_z),
        .end_time(out_ch.end_time), .in_use(out_ch.in_use),
        .store_full(out_ch.store_full)
    );
endmodule
`default_nettype wire

/* tb/sv/tb_keyframe_vector_lerp.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_keyframe_vector_lerp;
    import kvl_pkg::*;

    localparam int NKEYS = 32;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  func;
        logic        track;
        logic [31:0] key_time;
        logic [31:0] in_x;
        logic [31:0] in_y;
        logic [31:0] in_z;
    } key_cmd_t;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [31:0] end_time;
        logic        in_use;
        logic        store_full;
    } lerp_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    kvl_in_if in_ch();
    kvl_out_if out_ch();

    keyframe_vector_lerp #(.MAX_KEYS(NKEYS)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    // predictor state: shadow copy of both tracks
    logic [31:0] trk_time [2][NKEYS];
    logic signed [31:0] trk_vec [2][NKEYS][3];
    int unsigned trk_cnt [2];

    key_cmd_t cmd_q[$];
    lerp_res_t lerp_q[$];
    int errors = 0;
    int cycles = 0;
    int n_sent = 0;
    int n_results = 0;
    bit hold_send = 1'b0;
    bit in_acc = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] blend_comp(logic signed [31:0] a, logic signed [31:0] b,
                                               logic [16:0] frac);
        logic signed [63:0] sum;
        sum = 64'(a) * $signed({47'd0, 17'h10000 - frac})
            + 64'(b) * $signed({47'd0, frac});
        return 32'(sum >>> 16);
    endfunction

    // apply one transaction to the shadow tracks; return 1 with the result for a query
    function automatic bit predict_lerp(key_cmd_t c, output lerp_res_t r);
        int unsigned n;
        int unsigned i;
        int k;
        logic [31:0] t, cur, nxt, endt;
        logic [63:0] frac;
        logic [31:0] v [3];
        bit tr;
        tr = c.track;
        n = trk_cnt[tr];
        t = c.key_time;
        r = '0;
        if (c.func == FUNC_CLEAR)
        begin
            trk_cnt[tr] = 0;
            return 1'b0;
        end
        if (c.func == FUNC_APPEND)
        begin
            if (n < NKEYS)
            begin
                trk_time[tr][n] = t;
                trk_vec[tr][n][0] = c.in_x;
                trk_vec[tr][n][1] = c.in_y;
                trk_vec[tr][n][2] = c.in_z;
                trk_cnt[tr] = n + 1;
            end
            return 1'b0;
        end
        if (c.func != FUNC_QUERY)
            return 1'b0;
        if (n == 0)
        begin
            for (k = 0; k < 3; k++)
                v[k] = tr ? SCALE_ONE : 32'd0;
        end
        else if (n == 1 || t > trk_time[tr][n-1])
        begin
            for (k = 0; k < 3; k++)
                v[k] = (n == 1) ? trk_vec[tr][0][k] : trk_vec[tr][n-1][k];
        end
        else if (t <= trk_time[tr][0])
        begin
            for (k = 0; k < 3; k++)
                v[k] = trk_vec[tr][0][k];
        end
        else
        begin
            i = 0;
            while (i + 1 < n - 1 && trk_time[tr][i+1] < t)
                i++;
            cur = trk_time[tr][i];
            nxt = trk_time[tr][i+1];
            if (nxt <= cur)
                frac = 64'h10000;
            else
                frac = {16'd0, t - cur, 16'd0} / {32'd0, nxt - cur};
            for (k = 0; k < 3; k++)
                v[k] = (frac >= 64'h10000) ? trk_vec[tr][i+1][k]
                     : blend_comp(trk_vec[tr][i][k], trk_vec[tr][i+1][k], frac[16:0]);
        end
        endt = 0;
        if (trk_cnt[0] >= 2)
            endt = trk_time[0][trk_cnt[0]-1];
        if (trk_cnt[1] >= 2 && trk_time[1][trk_cnt[1]-1] > endt)
            endt = trk_time[1][trk_cnt[1]-1];
        r.out_x = v[0];
        r.out_y = v[1];
        r.out_z = v[2];
        r.end_time = endt;
        r.in_use = (trk_cnt[0] + trk_cnt[1]) != 0;
        r.store_full = n >= NKEYS;
        return 1'b1;
    endfunction

    function automatic key_cmd_t mk_cmd(logic [1:0] f, bit tr, logic [31:0] t,
                                        logic [31:0] x, logic [31:0] y, logic [31:0] z);
        key_cmd_t c;
        c.func = f;
        c.track = tr;
        c.key_time = t;
        c.in_x = x;
        c.in_y = y;
        c.in_z = z;
        return c;
    endfunction

    function automatic logic [31:0] rnd_vec();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
            default: return $urandom;
        endcase
    endfunction

    // input transaction accepted at the last rising edge
    always @(posedge clk)
    begin
        in_acc <= rst_n && in_ch.valid && in_ch.ready;
    end

    // driver: present pending transactions at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (in_ch.valid && !in_acc)
        begin
            // hold the current transaction
        end
        else if (in_ch.valid)
        begin
            // accepted at the last rising edge
            send_gap = rand_gap();
            if (send_gap == 0 && cmd_q.size() > 0 && !hold_send)
            begin
                {in_ch.func, in_ch.track, in_ch.key_time, in_ch.in_x, in_ch.in_y,
                 in_ch.in_z} <= cmd_q.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
        else if (send_gap > 0)
            send_gap--;
        else if (cmd_q.size() > 0 && !hold_send)
        begin
            {in_ch.func, in_ch.track, in_ch.key_time, in_ch.in_x, in_ch.in_y,
             in_ch.in_z} <= cmd_q.pop_front();
            in_ch.valid <= 1'b1;
        end
    end

    // receive side backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            recv_gap = rand_gap();
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin
        key_cmd_t c;
        lerp_res_t e;
        cycles++;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            c = {in_ch.func, in_ch.track, in_ch.key_time, in_ch.in_x, in_ch.in_y, in_ch.in_z};
            n_sent++;
            if (predict_lerp(c, e))
                lerp_q.push_back(e);
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_results++;
            if (lerp_q.size() == 0)
            begin
                $error("unexpected result x=%h", out_ch.out_x);
                errors++;
            end
            else
            begin
                e = lerp_q.pop_front();
                if (out_ch.out_x !== e.out_x)
                begin
                    $error("out_x expected %h actual %h", e.out_x, out_ch.out_x);
                    errors++;
                end
                if (out_ch.out_y !== e.out_y)
                begin
                    $error("out_y expected %h actual %h", e.out_y, out_ch.out_y);
                    errors++;
                end
                if (out_ch.out_z !== e.out_z)
                begin
                    $error("out_z expected %h actual %h", e.out_z, out_ch.out_z);
                    errors++;
                end
                if (out_ch.end_time !== e.end_time)
                begin
                    $error("end_time expected %h actual %h", e.end_time, out_ch.end_time);
                    errors++;
                end
                if (out_ch.in_use !== e.in_use)
                begin
                    $error("in_use expected %b actual %b", e.in_use, out_ch.in_use);
                    errors++;
                end
                if (out_ch.store_full !== e.store_full)
                begin
                    $error("store_full expected %b actual %b", e.store_full,
                           out_ch.store_full);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int k, j, nk, grp;
        bit tr;
        logic [31:0] base, t;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_NONE;
        in_ch.track = 1'b0;
        in_ch.key_time = '0;
        in_ch.in_x = '0;
        in_ch.in_y = '0;
        in_ch.in_z = '0;
        out_ch.ready = 1'b0;
        trk_cnt[0] = 0;
        trk_cnt[1] = 0;
        grp = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty defaults, single key, clamp, past end, equal times, func 3
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 0, 32'd100, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 1, 32'hFFFF_FFFF, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_APPEND, 0, 32'd1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 0, 32'd0, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_APPEND, 0, 32'd1000, 32'h1234, 32'hFFFF_0000, 32'd5));
        cmd_q.push_back(mk_cmd(FUNC_APPEND, 0, 32'd3000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'hFFFF_FFFF));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 0, 32'd999, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 0, 32'd1000, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 0, 32'd1001, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 0, 32'd2000, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 0, 32'd2999, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 0, 32'd3000, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 0, 32'hFFFF_FFFF, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_APPEND, 1, 32'hFFFF_FFFF, 32'd7, 32'd8, 32'd9));
        cmd_q.push_back(mk_cmd(FUNC_APPEND, 1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 1, 32'd5, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_NONE, 1, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 1, 32'd5, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_CLEAR, 1, 32'd0, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 1, 32'd5, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_CLEAR, 0, 32'd0, 0, 0, 0));
        cmd_q.push_back(mk_cmd(FUNC_QUERY, 0, 32'd5, 0, 0, 0));

        // random: build tracks of mostly ordered keys, query them, sprinkle noise
        while (n_sent + cmd_q.size() < 2000)
        begin
            // keep the queue short so the pressure pause can interleave
            while (cmd_q.size() > 40)
                @(posedge clk);
            tr = $urandom_range(0, 1);
            if (grp % 10 == 0)
            begin
                // sender waits for the block to drain completely
                hold_send = 1'b1;
                while (in_ch.valid || lerp_q.size() > 0)
                    @(posedge clk);
                repeat (70) @(posedge clk);
                hold_send = 1'b0;
            end
            grp++;
            cmd_q.push_back(mk_cmd(FUNC_CLEAR, tr, $urandom, $urandom, $urandom, $urandom));
            nk = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 6);
            base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
            t = base;
            for (k = 0; k < nk; k++)
            begin
                case ($urandom_range(0, 9))
                    0: t = t;
                    1: t = $urandom;
                    default: t = t + $urandom_range(1, 5000);
                endcase
                cmd_q.push_back(mk_cmd(FUNC_APPEND, tr, t, rnd_vec(), rnd_vec(), rnd_vec()));
            end
            for (j = 0; j < $urandom_range(2, 8); j++)
            begin
                case ($urandom_range(0, 9))
                    0: t = $urandom;
                    1: t = base;
                    2: t = 32'hFFFF_FFFF;
                    3: cmd_q.push_back(mk_cmd(FUNC_NONE, $urandom, $urandom, $urandom,
                                              $urandom, $urandom));
                    default: t = base + $urandom_range(0, 5000 * (nk + 1));
                endcase
                cmd_q.push_back(mk_cmd(FUNC_QUERY, $urandom_range(0, 4) ? tr : !tr, t,
                                       $urandom, $urandom, $urandom));
            end
        end

        // drain
        while (cmd_q.size() > 0 || in_ch.valid || lerp_q.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("sent %0d transactions, checked %0d query results over %0d cycles",
                 n_sent, n_results, cycles);
        $display("covered empty, single-key, clamp, past-end, zero-length and full tracks");
        if (errors == 0 && lerp_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
